// ===== rtl/rwl_pkg.sv =====
// ----------------------------------------------------------------------------
// rwl_pkg
// Shared constants, codes and control types of the readers-writer lock
// arbiter.
// ----------------------------------------------------------------------------
package rwl_pkg;

  localparam int RWL_QUEUE_DEPTH = 16;
  localparam int RWL_MAX_READERS = 255;
  localparam int REQUESTERS      = 256;
  localparam int MAX_RESULTS     = 16;
  localparam int GW              = $clog2(MAX_RESULTS);

  localparam logic [2:0] OP_RLOCK    = 3'd0;
  localparam logic [2:0] OP_WLOCK    = 3'd1;
  localparam logic [2:0] OP_RTRY     = 3'd2;
  localparam logic [2:0] OP_WTRY     = 3'd3;
  localparam logic [2:0] OP_RUNLOCK  = 3'd4;
  localparam logic [2:0] OP_WUNLOCK  = 3'd5;
  localparam logic [2:0] OP_DOWNGRADE = 3'd6;

  localparam logic [2:0] EV_RGRANT   = 3'd0;
  localparam logic [2:0] EV_WGRANT   = 3'd1;
  localparam logic [2:0] EV_QUEUED   = 3'd2;
  localparam logic [2:0] EV_TRYFAIL  = 3'd3;
  localparam logic [2:0] EV_RELEASED = 3'd4;
  localparam logic [2:0] EV_FULL     = 3'd5;
  localparam logic [2:0] EV_MISUSE   = 3'd6;

  typedef logic [7:0] req_map_t [256];

  function automatic req_map_t build_req_map();
    req_map_t m;
    for (int i = 0; i < 256; i++) begin
      m[i] = 8'(i % REQUESTERS);
    end
    return m;
  endfunction

  localparam req_map_t REQ_MAP = build_req_map();

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
  } rwl_cmd_t;

  typedef struct packed {
    logic first_more;
    logic step_more;
  } rwl_sts_t;

endpackage

// ===== rtl/rwl_dp.sv =====
// ----------------------------------------------------------------------------
// rwl_dp
// Lock state, wait queue memory, request decode and result register.
// ----------------------------------------------------------------------------
module rwl_dp import rwl_pkg::*; #(
  parameter int QUEUE_DEPTH = RWL_QUEUE_DEPTH,
  parameter int MAX_READERS = RWL_MAX_READERS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_requester,
  input  rwl_cmd_t   cmd,
  output rwl_sts_t   sts,
  output logic [2:0] out_event_res,
  output logic [7:0] out_who,
  output logic       out_last,
  output logic [7:0] out_readers_now
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW = $clog2(MAX_READERS + 1);

  localparam logic [1:0] WK_NONE = 2'd0;
  localparam logic [1:0] WK_ALL  = 2'd1;
  localparam logic [1:0] WK_RD   = 2'd2;

  logic [2:0]    op_r;
  logic [7:0]    req_r;
  logic [RW-1:0] rc_r;
  logic          wh_r;
  logic [QW-1:0] head_r;
  logic [FW-1:0] fill_r;
  logic [GW-1:0] gcnt_r;
  logic [8:0]    rd_r;
  logic [8:0]    rd2_r;
  logic [2:0]    ev_r;
  logic [7:0]    who_r;
  logic          last_r;
  logic [7:0]    rn_r;

  logic [8:0]    q_mem [QUEUE_DEPTH];

  logic [7:0]    req_m;
  logic [2:0]    ex_ev;
  logic [RW-1:0] ex_rc;
  logic          ex_wh;
  logic          ex_enq;
  logic [8:0]    ex_entry;
  logic [1:0]    ex_wake;
  logic          rc_lt_max;
  logic          q_full;
  logic          ent_w;
  logic          first_more;
  logic          step_more;
  logic [RW-1:0] rc_step;
  logic [QW-1:0] head_inc;
  logic [QW-1:0] head_nxt;
  logic [QW-1:0] head_nxt2;
  logic [QW:0]   tail_sum;
  logic [QW-1:0] tail;
  logic [RW+7:0] rn_ex;
  logic [RW+7:0] rn_st;

  assign req_m     = REQ_MAP[req_r];
  assign rc_lt_max = rc_r < RW'(MAX_READERS);
  assign q_full    = fill_r >= FW'(QUEUE_DEPTH);
  assign ent_w     = rd_r[8];

  assign head_inc  = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + QW'(1);
  assign head_nxt  = cmd.step ? head_inc : head_r;
  assign head_nxt2 = (head_nxt == QW'(QUEUE_DEPTH - 1)) ? '0 : head_nxt + QW'(1);
  assign tail_sum  = (QW+1)'(head_r) + (QW+1)'(fill_r);
  assign tail      = (tail_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                     QW'(tail_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);

  always_comb begin
    ex_ev    = EV_MISUSE;
    ex_rc    = rc_r;
    ex_wh    = wh_r;
    ex_enq   = 1'b0;
    ex_entry = {1'b0, req_m};
    ex_wake  = WK_NONE;
    unique case (op_r)
      OP_RLOCK: begin
        if (!wh_r && rc_lt_max && (rc_r != '0 || fill_r == '0)) begin
          ex_ev = EV_RGRANT;
          ex_rc = rc_r + RW'(1);
        end else if (!q_full) begin
          ex_enq = 1'b1;
          ex_ev  = EV_QUEUED;
        end else begin
          ex_ev = EV_FULL;
        end
      end
      OP_WLOCK: begin
        ex_entry = {1'b1, req_m};
        if (!wh_r && rc_r == '0) begin
          ex_ev = EV_WGRANT;
          ex_wh = 1'b1;
        end else if (!q_full) begin
          ex_enq = 1'b1;
          ex_ev  = EV_QUEUED;
        end else begin
          ex_ev = EV_FULL;
        end
      end
      OP_RTRY: begin
        if (!wh_r && fill_r == '0 && rc_lt_max) begin
          ex_ev = EV_RGRANT;
          ex_rc = rc_r + RW'(1);
        end else begin
          ex_ev = EV_TRYFAIL;
        end
      end
      OP_WTRY: begin
        if (!wh_r && rc_r == '0) begin
          ex_ev = EV_WGRANT;
          ex_wh = 1'b1;
        end else begin
          ex_ev = EV_TRYFAIL;
        end
      end
      OP_RUNLOCK: begin
        if (!wh_r && rc_r != '0) begin
          ex_ev = EV_RELEASED;
          ex_rc = rc_r - RW'(1);
          if (rc_r == RW'(1)) begin
            ex_wake = WK_ALL;
          end
        end
      end
      OP_WUNLOCK: begin
        if (wh_r) begin
          ex_ev   = EV_RELEASED;
          ex_rc   = '0;
          ex_wh   = 1'b0;
          ex_wake = WK_ALL;
        end
      end
      OP_DOWNGRADE: begin
        if (wh_r) begin
          ex_ev   = EV_RGRANT;
          ex_rc   = RW'(1);
          ex_wh   = 1'b0;
          ex_wake = WK_RD;
        end
      end
      default: ex_ev = EV_MISUSE;
    endcase
  end

  // wake lookahead: head entry in rd_r, the one behind it in rd2_r
  assign first_more = (ex_wake != WK_NONE) && (fill_r != '0) &&
                      (ent_w ? (ex_wake == WK_ALL && ex_rc == '0) :
                               (ex_rc < RW'(MAX_READERS)));
  assign step_more  = !ent_w && (fill_r > FW'(1)) && !rd2_r[8] &&
                      (rc_r < RW'(MAX_READERS - 1)) &&
                      (gcnt_r < GW'(MAX_RESULTS - 2));

  assign sts.first_more = first_more;
  assign sts.step_more  = step_more;

  assign rc_step = ent_w ? rc_r : rc_r + RW'(1);
  assign rn_ex   = {8'b0, ex_rc};
  assign rn_st   = {8'b0, rc_step};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r   <= '0;
      wh_r   <= 1'b0;
      head_r <= '0;
      fill_r <= '0;
      gcnt_r <= '0;
    end else if (cmd.exec) begin
      rc_r   <= ex_rc;
      wh_r   <= ex_wh;
      gcnt_r <= '0;
      if (ex_enq) begin
        fill_r <= fill_r + FW'(1);
      end
    end else if (cmd.step) begin
      head_r <= head_inc;
      fill_r <= fill_r - FW'(1);
      if (ent_w) begin
        wh_r <= 1'b1;
      end else begin
        rc_r   <= rc_r + RW'(1);
        gcnt_r <= gcnt_r + GW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      req_r <= in_requester;
    end
    if (cmd.exec) begin
      ev_r   <= ex_ev;
      who_r  <= req_m;
      last_r <= !first_more;
      rn_r   <= rn_ex[7:0];
    end else if (cmd.step) begin
      ev_r   <= ent_w ? EV_WGRANT : EV_RGRANT;
      who_r  <= rd_r[7:0];
      last_r <= !step_more;
      rn_r   <= rn_st[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && ex_enq) begin
      q_mem[tail] <= ex_entry;
    end
    rd_r  <= q_mem[head_nxt];
    rd2_r <= q_mem[head_nxt2];
  end

  assign out_event_res   = ev_r;
  assign out_who         = who_r;
  assign out_last        = last_r;
  assign out_readers_now = rn_r;

endmodule

// ===== rtl/rwl_ctrl.sv =====
// ----------------------------------------------------------------------------
// rwl_ctrl
// Sequencer: takes a request, runs its decode step, then one wake grant per
// cycle while the result slot is free, and holds the result valid flag.
// ----------------------------------------------------------------------------
module rwl_ctrl import rwl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  rwl_sts_t sts,
  output rwl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAKE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.exec  = 1'b1;
          state_nxt = sts.first_more ? S_WAKE : S_IDLE;
        end
      end
      S_WAKE: begin
        if (slot_free) begin
          cmd.step  = 1'b1;
          state_nxt = sts.step_more ? S_WAKE : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (cmd.exec || cmd.step) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/reader_writer_lock_arbiter_top.sv =====
// ----------------------------------------------------------------------------
// reader_writer_lock_arbiter_top
// Read-preferring readers-writer lock manager with a FIFO of waiting
// requesters; reports grants, queueing, failures and wakeups as a stream.
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (low bit up)                       tlast
// in_      in   operation[2:0] requester[10:3]                  -
// out_     out  event_res[2:0] who[10:3] readers_now[18:11]     last result
//
// a request is captured, then decoded and its first result registered
// each wake grant pops one queue entry, one queue pop per cycle while the
// result slot is free; the head entry is read from the queue memory ahead
// reset (rst_n low, synchronous) empties the queue and clears the lock state
// a stalled result holds the sequencer; the next request is taken while the
// last result of the previous one waits
// ----------------------------------------------------------------------------
module reader_writer_lock_arbiter_top import rwl_pkg::*; #(
  parameter int QUEUE_DEPTH = RWL_QUEUE_DEPTH,
  parameter int MAX_READERS = RWL_MAX_READERS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // operation[2:0], requester[10:3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // event_res[2:0], who[10:3], readers_now[18:11]
  output logic        out_tlast
);

  rwl_cmd_t   cmd;
  rwl_sts_t   sts;
  logic [2:0] ev;
  logic [7:0] who;
  logic [7:0] rn;

  rwl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rwl_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_READERS (MAX_READERS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_tdata[2:0]),
    .in_requester    (in_tdata[10:3]),
    .cmd             (cmd),
    .sts             (sts),
    .out_event_res   (ev),
    .out_who         (who),
    .out_last        (out_tlast),
    .out_readers_now (rn)
  );

  assign out_tdata = {5'b0, rn, who, ev};

  a_load_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_tready)
    else $error("intake open while a transaction is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec || cmd.step) |-> (!out_tvalid || out_tready))
    else $error("result register overwritten before transfer");

  a_wake_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && sts.first_more) |=> (out_tvalid && !out_tlast))
    else $error("first result marked last although a wake follows");

endmodule
